// ----- design/bba_pkg.sv -----
// Shared types and constants of the buddy block allocator.
// Used by bba_cfg, bba_ctrl, bba_dp and buddy_block_allocator; no dependencies.
package bba_pkg;

  localparam int unsigned MAX_MEMORY_DEF  = 4096;
  localparam int unsigned LEVEL_COUNT_DEF = 13;

  localparam int unsigned MEM_SIZE_W  = 13;
  localparam int unsigned CFG_LVL_W   = 4;
  localparam int unsigned ACTION_W    = 2;
  localparam int unsigned REQ_SIZE_W  = 16;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned VALUE_W     = 12;
  localparam int unsigned VALUE_MAX   = (1 << VALUE_W) - 1;
  // ceil(log2) of a REQ_SIZE_W-bit size spans 0..REQ_SIZE_W
  localparam int unsigned ROUND_LVL_W = 5;
  localparam int unsigned COUNT_W     = 13;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 4;
  localparam int unsigned REG_IDX_W   = 2;

  localparam logic [MEM_SIZE_W-1:0] MEM_SIZE_RST = 13'd4096;
  localparam logic [CFG_LVL_W-1:0]  SMALLEST_RST = 4'd0;
  localparam logic [CFG_LVL_W-1:0]  LARGEST_RST  = 4'd12;

  // Register indexes on the configuration port
  localparam logic [REG_IDX_W-1:0] REG_MEM_SIZE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SMALLEST = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LARGEST  = 2'd2;

  // Request kinds; the remaining codes are unsupported requests
  localparam logic [ACTION_W-1:0] ACT_INIT  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANT    = 2'd0,
    ST_NO_BLOCK = 2'd1,
    ST_UNSUP    = 2'd2,
    ST_INIT     = 2'd3
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic    capture;
    logic    init_top;
    logic    init_step;
    logic    calc;
    logic    search_step;
    logic    split;
    logic    take;
    logic    load_out;
    status_e kind;
  } bba_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_init;
    logic is_alloc;
    logic init_skip;
    logic init_last;
    logic calc_fail;
    logic has_free;
    logic j_at_top;
    logic j_is_lvl;
    logic split_last;
  } bba_stat_t;

endpackage

// ----- design/bba_cfg.sv -----
// Configuration register file of the buddy block allocator (APB-style port).
// Depends on bba_pkg.
module bba_cfg import bba_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [MEM_SIZE_W-1:0] memory_size_o,
  output logic [CFG_LVL_W-1:0]  smallest_level_o,
  output logic [CFG_LVL_W-1:0]  largest_level_o
);

  logic [MEM_SIZE_W-1:0] mem_size_q;
  logic [CFG_LVL_W-1:0]  smallest_q;
  logic [CFG_LVL_W-1:0]  largest_q;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_size_q <= MEM_SIZE_RST;
      smallest_q <= SMALLEST_RST;
      largest_q  <= LARGEST_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MEM_SIZE: mem_size_q <= pwdata[MEM_SIZE_W-1:0];
        REG_SMALLEST: smallest_q <= pwdata[CFG_LVL_W-1:0];
        REG_LARGEST:  largest_q  <= pwdata[CFG_LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MEM_SIZE: prdata = APB_DATA_W'(mem_size_q);
      REG_SMALLEST: prdata = APB_DATA_W'(smallest_q);
      REG_LARGEST:  prdata = APB_DATA_W'(largest_q);
      default:      prdata = '0;
    endcase
  end

  assign memory_size_o    = mem_size_q;
  assign smallest_level_o = smallest_q;
  assign largest_level_o  = largest_q;

endmodule

// ----- design/bba_ctrl.sv -----
// Sequencing state machine of the buddy block allocator.
// Depends on bba_pkg; drives bba_dp through bba_cmd_t, reads bba_stat_t.
module bba_ctrl import bba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  bba_stat_t stat_i,
  output bba_cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DECODE   = 9'b000000010,
    S_INIT_TOP = 9'b000000100,
    S_INIT_LVL = 9'b000001000,
    S_CALC     = 9'b000010000,
    S_SEARCH   = 9'b000100000,
    S_SPLIT    = 9'b001000000,
    S_TAKE     = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_e;

  state_e  state_q, state_d;
  status_e kind_q, kind_d;
  logic    out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.kind  = kind_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.is_init) begin
          state_d = S_INIT_TOP;
        end else if (stat_i.is_alloc) begin
          state_d = S_CALC;
        end else begin
          kind_d  = ST_UNSUP;
          state_d = S_DONE;
        end
      end
      S_INIT_TOP: begin
        cmd_o.init_top = 1'b1;
        kind_d         = ST_INIT;
        state_d        = stat_i.init_skip ? S_DONE : S_INIT_LVL;
      end
      S_INIT_LVL: begin
        if (stat_i.init_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.init_step = 1'b1;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        if (stat_i.calc_fail) begin
          kind_d  = ST_NO_BLOCK;
          state_d = S_DONE;
        end else begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat_i.has_free) begin
          state_d = stat_i.j_is_lvl ? S_TAKE : S_SPLIT;
        end else if (stat_i.j_at_top) begin
          kind_d  = ST_NO_BLOCK;
          state_d = S_DONE;
        end else begin
          cmd_o.search_step = 1'b1;
        end
      end
      S_SPLIT: begin
        cmd_o.split = 1'b1;
        if (stat_i.split_last) begin
          state_d = S_TAKE;
        end
      end
      S_TAKE: begin
        cmd_o.take = 1'b1;
        kind_d     = ST_GRANT;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= ST_UNSUP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_split_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.split |-> stat_i.has_free)
    else $error("split issued on an empty level");
  a_take_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take |-> (stat_i.has_free && stat_i.j_is_lvl))
    else $error("take issued on an empty or wrong level");
  a_search_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.search_step |-> !stat_i.j_at_top)
    else $error("search stepped past the largest level");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.load_out)
    else $error("pending result overwritten");
`endif

endmodule

// ----- design/bba_dp.sv -----
// Datapath of the buddy block allocator: free lists, carve and split arithmetic,
// result register. Depends on bba_pkg; commanded by bba_ctrl.
module bba_dp import bba_pkg::*; #(
  parameter int unsigned MAX_MEMORY  = MAX_MEMORY_DEF,
  parameter int unsigned LEVEL_COUNT = LEVEL_COUNT_DEF,
  parameter int unsigned ADDR_W      = VALUE_W,
  parameter int unsigned LVL_W       = $clog2(LEVEL_COUNT)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [MEM_SIZE_W-1:0] memory_size_i,
  input  logic [CFG_LVL_W-1:0]  smallest_level_i,
  input  logic [CFG_LVL_W-1:0]  largest_level_i,
  input  logic [ACTION_W-1:0]   action_i,
  input  logic [REQ_SIZE_W-1:0] request_size_i,
  input  bba_cmd_t              cmd_i,
  output bba_stat_t             stat_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [VALUE_W-1:0]    value_o
);

  localparam logic [ROUND_LVL_W-1:0] LVL_LAST = ROUND_LVL_W'(LEVEL_COUNT - 1);

  logic [ACTION_W-1:0]   action_q;
  logic [REQ_SIZE_W-1:0] size_q;
  logic [LVL_W-1:0]      lvl_q, j_q, j_dn;
  logic [MEM_SIZE_W-1:0] rem_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [COUNT_W-1:0]    top_next_q, top_cnt_q;
  logic [ADDR_W-1:0]     first_q  [LEVEL_COUNT];
  logic [ADDR_W-1:0]     second_q [LEVEL_COUNT];
  logic [1:0]            cnt_q    [LEVEL_COUNT];
  logic [STATUS_W-1:0]   out_status_q;
  logic [VALUE_W-1:0]    out_value_q;

  logic [ROUND_LVL_W-1:0] small_ext, large_ext, small_cl, large_cl;
  logic [ROUND_LVL_W-1:0] round_lvl, eff_lvl;
  logic [LVL_W-1:0]       s_lvl, t_lvl;
  logic [MEM_SIZE_W-1:0]  rem_init, top_n;
  logic [31:0]            top_span, top_addr_full, blk;
  logic [ADDR_W-1:0]      head_addr;
  logic                   init_skip, init_fits, j_at_top;
  logic [VALUE_W-1:0]     rem_sat;

  // Clamp the level registers to the implemented levels
  assign small_ext = ROUND_LVL_W'(smallest_level_i);
  assign large_ext = ROUND_LVL_W'(largest_level_i);
  assign small_cl  = (small_ext > LVL_LAST) ? LVL_LAST : small_ext;
  assign large_cl  = (large_ext > LVL_LAST) ? LVL_LAST : large_ext;
  assign s_lvl     = small_cl[LVL_W-1:0];
  assign t_lvl     = large_cl[LVL_W-1:0];
  assign init_skip = small_cl > large_cl;

  assign rem_init = (32'(memory_size_i) > 32'(MAX_MEMORY)) ? MEM_SIZE_W'(MAX_MEMORY)
                                                           : memory_size_i;
  assign top_n    = rem_init >> t_lvl;
  assign top_span = 32'(top_n) << t_lvl;

  assign j_dn      = j_q - 1'b1;
  assign blk       = 32'd1 << j_dn;
  assign init_fits = 32'(rem_q) >= blk;

  // Round the request up to a power of two
  always_comb begin
    round_lvl = '0;
    for (int l = 0; l < REQ_SIZE_W; l++) begin
      if ((32'd1 << l) < 32'(size_q)) begin
        round_lvl = ROUND_LVL_W'(l + 1);
      end
    end
  end
  assign eff_lvl = (round_lvl < small_cl) ? small_cl : round_lvl;

  assign j_at_top      = j_q == t_lvl;
  assign top_addr_full = 32'(top_next_q) << t_lvl;
  assign head_addr     = j_at_top ? top_addr_full[ADDR_W-1:0] : first_q[j_q];

  assign rem_sat = (rem_q > MEM_SIZE_W'(VALUE_MAX)) ? VALUE_W'(VALUE_MAX)
                                                    : rem_q[VALUE_W-1:0];

  always_comb begin
    stat_o            = '0;
    stat_o.is_init    = action_q == ACT_INIT;
    stat_o.is_alloc   = action_q == ACT_ALLOC;
    stat_o.init_skip  = init_skip;
    stat_o.init_last  = j_q == s_lvl;
    stat_o.calc_fail  = (size_q == '0) || (eff_lvl > large_cl);
    stat_o.has_free   = j_at_top ? (top_cnt_q != '0) : (cnt_q[j_q] != 2'd0);
    stat_o.j_at_top   = j_at_top;
    stat_o.j_is_lvl   = j_q == lvl_q;
    stat_o.split_last = (LVL_W + 1)'(j_q) == ((LVL_W + 1)'(lvl_q) + 1'b1);
  end

  // Free-list counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_next_q <= '0;
      top_cnt_q  <= '0;
      for (int i = 0; i < LEVEL_COUNT; i++) begin
        cnt_q[i] <= 2'd0;
      end
    end else begin
      if (cmd_i.init_top) begin
        top_next_q <= '0;
        top_cnt_q  <= init_skip ? '0 : COUNT_W'(top_n);
        for (int i = 0; i < LEVEL_COUNT; i++) begin
          cnt_q[i] <= 2'd0;
        end
      end
      if (cmd_i.init_step && init_fits) begin
        cnt_q[j_dn] <= 2'd1;
      end
      if (cmd_i.split || cmd_i.take) begin
        if (j_at_top) begin
          top_next_q <= top_next_q + 1'b1;
          top_cnt_q  <= top_cnt_q - 1'b1;
        end else begin
          cnt_q[j_q] <= cnt_q[j_q] - 1'b1;
        end
      end
      if (cmd_i.split) begin
        cnt_q[j_dn] <= 2'd2;
      end
    end
  end

  // Block addresses, valid only where the counters say so
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_step && init_fits) begin
      first_q[j_dn] <= addr_q;
    end
    if ((cmd_i.split || cmd_i.take) && !j_at_top && (cnt_q[j_q] == 2'd2)) begin
      first_q[j_q] <= second_q[j_q];
    end
    if (cmd_i.split) begin
      first_q[j_dn]  <= head_addr;
      second_q[j_dn] <= head_addr ^ blk[ADDR_W-1:0];
    end
  end

  // Item, cursors and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= action_i;
      size_q   <= request_size_i;
    end
    if (cmd_i.init_top) begin
      rem_q  <= init_skip ? rem_init : rem_init - top_span[MEM_SIZE_W-1:0];
      addr_q <= top_span[ADDR_W-1:0];
      j_q    <= t_lvl;
    end
    if (cmd_i.init_step) begin
      j_q <= j_dn;
      if (init_fits) begin
        addr_q <= addr_q + blk[ADDR_W-1:0];
        rem_q  <= rem_q - blk[MEM_SIZE_W-1:0];
      end
    end
    if (cmd_i.calc) begin
      lvl_q <= eff_lvl[LVL_W-1:0];
      j_q   <= eff_lvl[LVL_W-1:0];
    end
    if (cmd_i.search_step) begin
      j_q <= j_q + 1'b1;
    end
    if (cmd_i.split) begin
      j_q <= j_dn;
    end
    if (cmd_i.take) begin
      addr_q <= head_addr;
    end
    if (cmd_i.load_out) begin
      out_status_q <= cmd_i.kind;
      case (cmd_i.kind)
        ST_GRANT: out_value_q <= addr_q[VALUE_W-1:0];
        ST_INIT:  out_value_q <= rem_sat;
        default:  out_value_q <= '0;
      endcase
    end
  end

  assign status_o = out_status_q;
  assign value_o  = out_value_q;

endmodule

// ----- design/buddy_block_allocator.sv -----
// Top level of the buddy block allocator: stream ports, APB registers,
// controller and datapath. Depends on bba_pkg, bba_cfg, bba_ctrl and bba_dp.
//
// Buddy allocator over up to MAX_MEMORY units, allocation only. Level k holds
// blocks of 2^k units; the largest level keeps a counted run of blocks, every
// smaller level keeps up to two free blocks. An initialize request (tuser 0)
// carves memory_size from the largest level down to the smallest and returns
// the unused remainder with status 3 (saturated at 4095). An allocate request
// (tuser 1) rounds request_size up to a power of two, at least the smallest
// level; if that level is empty, the lowest non-empty level above it is split
// down, block first then buddy. It returns the block address with status 0,
// or status 1 when no block fits (a size of zero always fails). Other request
// kinds return status 2. Items are processed one at a time; a finished result
// waits in an output register while the next item is accepted. The controller
// walks the free-list registers one level per cycle. There is no clearing pass
// after reset.
// Write the configuration registers only while no item is in flight, and
// initialize again after changing them.
module buddy_block_allocator import bba_pkg::*; #(
  parameter int unsigned MAX_MEMORY  = MAX_MEMORY_DEF,
  parameter int unsigned LEVEL_COUNT = LEVEL_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,   // [15:0] request_size
  input  logic [1:0]            s_axis_tuser,   // [1:0] action
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,   // [11:0] value, [15:12] zero
  output logic [1:0]            m_axis_tuser,   // [1:0] status
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Stored addresses are at least as wide as the reported value
  localparam int unsigned ADDR_W = ($clog2(MAX_MEMORY) > VALUE_W) ? $clog2(MAX_MEMORY)
                                                                  : VALUE_W;
  localparam int unsigned LVL_W  = $clog2(LEVEL_COUNT);

  logic [MEM_SIZE_W-1:0] memory_size;
  logic [CFG_LVL_W-1:0]  smallest_level;
  logic [CFG_LVL_W-1:0]  largest_level;
  bba_cmd_t              cmd;
  bba_stat_t             stat;
  logic [VALUE_W-1:0]    value;

  bba_cfg u_cfg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .memory_size_o    (memory_size),
    .smallest_level_o (smallest_level),
    .largest_level_o  (largest_level)
  );

  // Sequence each transaction: decode, carve or search/split (unsupported requests skip both), then hold the result
  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bba_dp #(
    .MAX_MEMORY  (MAX_MEMORY),
    .LEVEL_COUNT (LEVEL_COUNT),
    .ADDR_W      (ADDR_W),
    .LVL_W       (LVL_W)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .memory_size_i    (memory_size),
    .smallest_level_i (smallest_level),
    .largest_level_i  (largest_level),
    .action_i         (s_axis_tuser),
    .request_size_i   (s_axis_tdata),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .status_o         (m_axis_tuser),
    .value_o          (value)
  );

  // Pad the value to whole bytes
  assign m_axis_tdata = {(16 - VALUE_W)'(0), value};

endmodule
